>>> sv/bsct_pkg.sv
// ----------------------------------------------------------------------------
// bsct_pkg
// Shared types and constants for the bright spot centroid tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package bsct_pkg;

    localparam int COLS = 128;
    localparam int ROWS = 64;

    localparam int COL_W     = 7;
    localparam int ROW_W     = 6;
    localparam int PIX_W     = 8;
    localparam int CNT_W     = 13;
    localparam int SCOL_W    = 20;
    localparam int SROW_W    = 19;
    localparam int DIV_STEPS = COL_W;
    localparam int STEP_W    = 3;
    localparam int REM_W     = SCOL_W - DIV_STEPS;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_SCANNED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT   = 2'd2;

    localparam logic [7:0] THRESHOLD_RST    = 8'd14;
    localparam logic [6:0] ROWS_SCANNED_RST = 7'd29;
    localparam logic [7:0] LOST_LIMIT_RST   = 8'd5;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } in_item_t;

    typedef struct packed {
        logic [6:0]       center_x;
        logic [5:0]       center_y;
        logic             beacon_lost;
        logic             beacon_started;
        logic [CNT_W-1:0] hit_total;
    } out_item_t;

    typedef struct packed {
        logic pix_take;
        logic div_step;
        logic res_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic frame_end;
    } ctrl_status_t;

endpackage : bsct_pkg

`default_nettype wire

>>> sv/bsct_datapath.sv
// ----------------------------------------------------------------------------
// bsct_datapath
// Pixel position counters, hit sums, two shared-step dividers and the
// tracking state with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsct_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire bsct_pkg::in_item_t               in_item,
    input  wire logic                             cfg_valid,
    input  wire logic [bsct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bsct_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  wire bsct_pkg::ctrl_cmd_t              cmd,
    output bsct_pkg::ctrl_status_t                status,
    output bsct_pkg::out_item_t                   out_item
);
    import bsct_pkg::*;

    logic [7:0]        threshold_reg;
    logic [6:0]        rows_scanned_reg;
    logic [7:0]        lost_limit_reg;

    logic [ROW_W-1:0]  row_pos_reg;
    logic [COL_W-1:0]  col_pos_reg;
    logic [1:0]        prev_bright_reg;
    logic [SCOL_W-1:0] sum_col_reg;
    logic [SROW_W-1:0] sum_row_reg;
    logic [CNT_W-1:0]  hit_count_reg;
    logic [7:0]        miss_count_reg;
    logic [6:0]        held_x_reg;
    logic [5:0]        held_y_reg;
    logic              lost_reg;
    logic              started_reg;

    logic [REM_W-1:0]     rem_x_reg;
    logic [REM_W-1:0]     rem_y_reg;
    logic [DIV_STEPS-1:0] num_x_reg;
    logic [DIV_STEPS-1:0] num_y_reg;
    logic [DIV_STEPS-1:0] quo_x_reg;
    logic [DIV_STEPS-1:0] quo_y_reg;
    logic [CNT_W-1:0]     den_reg;

    out_item_t         out_reg;

    logic [ROW_W-1:0]  eff_row;
    logic [COL_W-1:0]  eff_col;
    logic [1:0]        eff_prev;
    logic [SCOL_W-1:0] eff_sum_col;
    logic [SROW_W-1:0] eff_sum_row;
    logic [CNT_W-1:0]  eff_count;
    logic              bright;
    logic              hit;
    logic [SCOL_W-1:0] sum_col_next;
    logic [SROW_W-1:0] sum_row_next;
    logic [CNT_W-1:0]  hit_count_next;
    logic [SCOL_W-1:0] sum_row_wide;

    logic [REM_W:0]    trial_x;
    logic [REM_W:0]    trial_y;
    logic [REM_W:0]    diff_x;
    logic [REM_W:0]    diff_y;
    logic              ge_x;
    logic              ge_y;

    logic [7:0]        miss_inc;
    logic              goes_lost;

    always_comb
    begin
        eff_row     = in_item.frame_start ? '0 : row_pos_reg;
        eff_col     = in_item.frame_start ? '0 : col_pos_reg;
        eff_prev    = in_item.frame_start ? '0 : prev_bright_reg;
        eff_sum_col = in_item.frame_start ? '0 : sum_col_reg;
        eff_sum_row = in_item.frame_start ? '0 : sum_row_reg;
        eff_count   = in_item.frame_start ? '0 : hit_count_reg;

        bright = in_item.pixel > threshold_reg;
        hit    = (eff_col >= COL_W'(2)) && ({1'b0, eff_row} < rows_scanned_reg)
                 && (eff_prev == 2'b11) && bright;

        sum_col_next   = eff_sum_col
                         + (hit ? SCOL_W'(eff_col - COL_W'(1)) : SCOL_W'(0));
        sum_row_next   = eff_sum_row + (hit ? SROW_W'(eff_row) : SROW_W'(0));
        hit_count_next = eff_count + (hit ? CNT_W'(1) : CNT_W'(0));
        sum_row_wide   = SCOL_W'(sum_row_next);

        status.frame_end = (eff_row == ROW_W'(ROWS - 1)) && (eff_col == COL_W'(COLS - 1));

        trial_x = {rem_x_reg, num_x_reg[DIV_STEPS-1]};
        trial_y = {rem_y_reg, num_y_reg[DIV_STEPS-1]};
        diff_x  = trial_x - {1'b0, den_reg};
        diff_y  = trial_y - {1'b0, den_reg};
        ge_x    = trial_x >= {1'b0, den_reg};
        ge_y    = trial_y >= {1'b0, den_reg};

        miss_inc  = (miss_count_reg < lost_limit_reg) ? miss_count_reg + 8'd1
                                                      : miss_count_reg;
        goes_lost = miss_inc >= lost_limit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RST;
            rows_scanned_reg <= ROWS_SCANNED_RST;
            lost_limit_reg   <= LOST_LIMIT_RST;
            row_pos_reg      <= '0;
            col_pos_reg      <= '0;
            prev_bright_reg  <= '0;
            sum_col_reg      <= '0;
            sum_row_reg      <= '0;
            hit_count_reg    <= '0;
            miss_count_reg   <= '0;
            held_x_reg       <= '0;
            held_y_reg       <= '0;
            lost_reg         <= 1'b0;
            started_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_THRESHOLD:    threshold_reg    <= cfg_data;
                    CFG_ROWS_SCANNED: rows_scanned_reg <= cfg_data[6:0];
                    CFG_LOST_LIMIT:   lost_limit_reg   <= cfg_data;
                    default:          ;
                endcase
            end

            if (cmd.pix_take)
            begin
                if (status.frame_end)
                begin
                    row_pos_reg     <= '0;
                    col_pos_reg     <= '0;
                    prev_bright_reg <= '0;
                    sum_col_reg     <= '0;
                    sum_row_reg     <= '0;
                    hit_count_reg   <= '0;
                end
                else
                begin
                    prev_bright_reg <= {eff_prev[0], bright};
                    sum_col_reg     <= sum_col_next;
                    sum_row_reg     <= sum_row_next;
                    hit_count_reg   <= hit_count_next;
                    if (eff_col == COL_W'(COLS - 1))
                    begin
                        col_pos_reg <= '0;
                        row_pos_reg <= eff_row + ROW_W'(1);
                    end
                    else
                    begin
                        col_pos_reg <= eff_col + COL_W'(1);
                        row_pos_reg <= eff_row;
                    end
                end
            end

            if (cmd.res_load)
            begin
                if (den_reg != '0)
                begin
                    held_x_reg     <= quo_x_reg[6:0];
                    held_y_reg     <= quo_y_reg[5:0];
                    started_reg    <= 1'b1;
                    miss_count_reg <= '0;
                    lost_reg       <= 1'b0;
                end
                else
                begin
                    miss_count_reg <= miss_inc;
                    if (goes_lost)
                    begin
                        lost_reg   <= 1'b1;
                        held_x_reg <= '0;
                        held_y_reg <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pix_take && status.frame_end)
        begin
            rem_x_reg <= sum_col_next[SCOL_W-1:DIV_STEPS];
            rem_y_reg <= sum_row_wide[SCOL_W-1:DIV_STEPS];
            num_x_reg <= sum_col_next[DIV_STEPS-1:0];
            num_y_reg <= sum_row_wide[DIV_STEPS-1:0];
            den_reg   <= hit_count_next;
            quo_x_reg <= '0;
            quo_y_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_x_reg <= ge_x ? diff_x[REM_W-1:0] : trial_x[REM_W-1:0];
            rem_y_reg <= ge_y ? diff_y[REM_W-1:0] : trial_y[REM_W-1:0];
            num_x_reg <= {num_x_reg[DIV_STEPS-2:0], 1'b0};
            num_y_reg <= {num_y_reg[DIV_STEPS-2:0], 1'b0};
            quo_x_reg <= {quo_x_reg[DIV_STEPS-2:0], ge_x};
            quo_y_reg <= {quo_y_reg[DIV_STEPS-2:0], ge_y};
        end

        if (cmd.res_load)
        begin
            out_reg.hit_total <= den_reg;
            if (den_reg != '0)
            begin
                out_reg.center_x       <= quo_x_reg[6:0];
                out_reg.center_y       <= quo_y_reg[5:0];
                out_reg.beacon_lost    <= 1'b0;
                out_reg.beacon_started <= 1'b1;
            end
            else
            begin
                out_reg.center_x       <= goes_lost ? 7'd0 : held_x_reg;
                out_reg.center_y       <= goes_lost ? 6'd0 : held_y_reg;
                out_reg.beacon_lost    <= goes_lost | lost_reg;
                out_reg.beacon_started <= started_reg;
            end
        end
    end

    assign out_item = out_reg;

endmodule : bsct_datapath

`default_nettype wire

>>> sv/bsct_controller.sv
// ----------------------------------------------------------------------------
// bsct_controller
// Sequences pixel intake, the division steps at frame end and the hand-off
// of each result item into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsct_controller (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire bsct_pkg::ctrl_status_t status,
    output bsct_pkg::ctrl_cmd_t         cmd
);
    import bsct_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    assign in_ready  = (state_reg == ST_RUN);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.pix_take   = 1'b0;
        cmd.div_step   = 1'b0;
        cmd.res_load   = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                cmd.pix_take = in_valid;
                if (in_valid && status.frame_end)
                begin
                    state_next = ST_DIV;
                    step_next  = '0;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_end_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pix_take && status.frame_end |=> state_reg == ST_DIV)
        else $error("frame end did not start the division");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> out_valid_reg)
        else $error("result load did not raise out_valid");

    a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("out_valid rose outside the finish state");

    a_no_load_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> out_free)
        else $error("result load would overwrite a waiting item");

endmodule : bsct_controller

`default_nettype wire

>>> sv/bright_spot_centroid_tracker.sv
// ----------------------------------------------------------------------------
// bright_spot_centroid_tracker
// Thresholded blob centroid over the upper rows of a raster-scanned frame.
//
//   Channel   Signals                          Direction
//   in        in_valid, in_ready, in_item      pixel items into the block
//   out       out_valid, out_ready, out_item   one result item per frame
//   cfg       cfg_valid, cfg_ready, cfg_index  register writes, always ready
//             cfg_data
//
// Pixels are taken whenever in_valid is high in the run state. After the last
// pixel of a frame, in_ready stays low while the bit-serial centroid dividers
// step and until the output register is loaded. An untaken result item stalls
// only the next frame end, not the pixels before it. Reset returns all but the
// divider and output registers to their defaults and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bright_spot_centroid_tracker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire bsct_pkg::in_item_t             in_item,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output bsct_pkg::out_item_t                 out_item,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bsct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bsct_pkg::CFG_DAT_W-1:0] cfg_data
);
    import bsct_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign cfg_ready = 1'b1;

    bsct_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bsct_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item)
    );

endmodule : bright_spot_centroid_tracker

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bright spot centroid tracker. Whole frames of
// pixel items are queued and sent over the input channel. Each accepted item
// updates a cycle-free model of the tracker that predicts the per-frame
// centroid result. Frames cover directed corner cases (flat frames at the
// threshold and rows limits, empty-frame runs against the miss limit,
// dropped partial frames and counter wrap) and then random scenes under
// changing register settings and several handshake pacing phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bsct_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT   = 10_000_000;

    typedef enum int {SCENE_DARK, SCENE_FLAT, SCENE_NOISE, SCENE_SPOTS} scene_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
    } reg_write_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_THRESHOLD;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    in_item_t    pixel_backlog[$];
    reg_write_t  reg_write_backlog[$];
    out_item_t   due_centroids[$];
    reg_write_t  next_write;
    out_item_t   due;

    int unsigned send_idle_pct   = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned mismatches      = 0;
    int unsigned pixels_taken    = 0;
    int unsigned frames_checked  = 0;
    int unsigned reg_writes_done = 0;
    int unsigned cycle_count     = 0;

    logic [7:0]      thr_q   = THRESHOLD_RST;
    logic [6:0]      rows_q  = ROWS_SCANNED_RST;
    logic [7:0]      limit_q = LOST_LIMIT_RST;
    int unsigned     row_at  = 0;
    int unsigned     col_at  = 0;
    logic [1:0]      bright_hist = '0;
    longint unsigned col_sum = 0;
    longint unsigned row_sum = 0;
    int unsigned     hits    = 0;
    int unsigned     misses  = 0;
    logic [6:0]      cx      = '0;
    logic [5:0]      cy      = '0;
    logic            lost    = 1'b0;
    logic            started = 1'b0;

    bright_spot_centroid_tracker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void restart_frame();
        row_at      = 0;
        col_at      = 0;
        bright_hist = '0;
        col_sum     = 0;
        row_sum     = 0;
        hits        = 0;
    endfunction

    function automatic void track_pixel(input in_item_t it);
        out_item_t res;
        logic      lit;
        if (it.frame_start)
        begin
            restart_frame();
        end
        lit = (it.pixel > thr_q);
        if (col_at >= 2 && row_at < rows_q && bright_hist == 2'b11 && lit)
        begin
            col_sum += col_at - 1;
            row_sum += row_at;
            hits++;
        end
        bright_hist = {bright_hist[0], lit};
        if (row_at >= ROWS - 1 && col_at >= COLS - 1)
        begin
            if (hits != 0)
            begin
                cx      = 7'(col_sum / hits);
                cy      = 6'(row_sum / hits);
                started = 1'b1;
                misses  = 0;
                lost    = 1'b0;
            end
            else
            begin
                if (misses < limit_q)
                begin
                    misses++;
                end
                if (misses >= limit_q)
                begin
                    lost = 1'b1;
                    cx   = '0;
                    cy   = '0;
                end
            end
            res.center_x       = cx;
            res.center_y       = cy;
            res.beacon_lost    = lost;
            res.beacon_started = started;
            res.hit_total      = CNT_W'(hits);
            due_centroids.push_back(res);
            restart_frame();
        end
        else if (col_at >= COLS - 1)
        begin
            col_at = 0;
            row_at++;
        end
        else
        begin
            col_at++;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                track_pixel(in_item);
                pixels_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_item  <= pixel_backlog.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_centroids.size() == 0)
                begin
                    $error("result item arrived with none expected");
                    mismatches++;
                end
                else
                begin
                    due = due_centroids.pop_front();
                    check_field("center_x", due.center_x, out_item.center_x);
                    check_field("center_y", due.center_y, out_item.center_y);
                    check_field("beacon_lost", due.beacon_lost, out_item.beacon_lost);
                    check_field("beacon_started", due.beacon_started,
                                out_item.beacon_started);
                    check_field("hit_total", due.hit_total, out_item.hit_total);
                    frames_checked++;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= CFG_THRESHOLD;
            cfg_data  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_THRESHOLD:    thr_q   = cfg_data;
                    CFG_ROWS_SCANNED: rows_q  = cfg_data[6:0];
                    CFG_LOST_LIMIT:   limit_q = cfg_data;
                    default:          ;
                endcase
                reg_writes_done++;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_write_backlog.size() != 0)
                begin
                    next_write = reg_write_backlog.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= next_write.idx;
                    cfg_data  <= next_write.data;
                end
                else
                begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, due_centroids.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] dim_value();
        return 8'($urandom_range(0, thr_q));
    endfunction

    function automatic logic [7:0] bright_value();
        return (thr_q == 8'd255) ? 8'd255 : 8'($urandom_range(thr_q + 1, 255));
    endfunction

    task automatic drain();
        do @(negedge clk);
        while (pixel_backlog.size() != 0 || in_valid || due_centroids.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        reg_write_t w;
        drain();
        w.idx  = idx;
        w.data = val;
        reg_write_backlog.push_back(w);
        do @(negedge clk);
        while (reg_write_backlog.size() != 0 || cfg_valid);
    endtask

    task automatic queue_partial(input int unsigned count, input logic mark_start);
        in_item_t it;
        for (int unsigned i = 0; i < count; i++)
        begin
            it.pixel       = 8'($urandom);
            it.frame_start = mark_start && i == 0;
            pixel_backlog.push_back(it);
        end
    endtask

    task automatic queue_frame(input scene_t scene, input logic [7:0] level,
                               input logic mark_start);
        int unsigned spot_cnt;
        int unsigned span;
        int unsigned top[3];
        int unsigned bot[3];
        int unsigned lft[3];
        int unsigned rgt[3];
        logic        in_spot;
        in_item_t    it;
        spot_cnt = $urandom_range(1, 3);
        span = (rows_q == 0 || rows_q > ROWS) ? ROWS : rows_q;
        for (int k = 0; k < 3; k++)
        begin
            top[k] = $urandom_range(0, span - 1);
            bot[k] = top[k] + $urandom_range(0, 12);
            lft[k] = $urandom_range(0, COLS - 1);
            rgt[k] = lft[k] + $urandom_range(2, 30);
        end
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                in_spot = 1'b0;
                for (int k = 0; k < spot_cnt; k++)
                begin
                    if (r >= top[k] && r <= bot[k] && c >= lft[k] && c <= rgt[k])
                    begin
                        in_spot = 1'b1;
                    end
                end
                case (scene)
                    SCENE_FLAT:  it.pixel = level;
                    SCENE_NOISE: it.pixel = 8'($urandom);
                    SCENE_DARK:
                        it.pixel = ($urandom_range(0, 49) == 0) ? bright_value() : dim_value();
                    default:     it.pixel = in_spot ? bright_value() : dim_value();
                endcase
                it.frame_start = mark_start && r == 0 && c == 0;
                pixel_backlog.push_back(it);
            end
        end
    endtask

    task automatic run_phase(input int frames, input int unsigned send_pct,
                             input int unsigned recv_pct);
        logic        resync;
        int unsigned pick;
        scene_t      scene;
        drain();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int f = 0; f < frames; f++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg(CFG_THRESHOLD, ($urandom_range(0, 9) == 0)
                          ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                          : 8'($urandom_range(0, 200)));
                write_reg(CFG_ROWS_SCANNED, ($urandom_range(0, 4) == 0)
                          ? 8'($urandom) : 8'($urandom_range(1, 64)));
                write_reg(CFG_LOST_LIMIT, ($urandom_range(0, 3) == 0)
                          ? 8'($urandom) : 8'($urandom_range(0, 4)));
            end
            resync = 1'b0;
            if ($urandom_range(0, 9) == 0)
            begin
                queue_partial($urandom_range(1, COLS * ROWS - 1), 1'($urandom_range(0, 1)));
                resync = 1'b1;
            end
            pick  = $urandom_range(0, 9);
            scene = (pick < 2) ? SCENE_DARK : (pick == 2) ? SCENE_FLAT :
                    (pick == 3) ? SCENE_NOISE : SCENE_SPOTS;
            queue_frame(scene, 8'($urandom), resync || $urandom_range(0, 9) < 7);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_frame(SCENE_SPOTS, 8'd0, 1'b1);
        write_reg(CFG_LOST_LIMIT, 8'd0);
        queue_frame(SCENE_DARK, 8'd0, 1'b1);
        write_reg(CFG_THRESHOLD, 8'd0);
        write_reg(CFG_ROWS_SCANNED, 8'd64);
        queue_frame(SCENE_FLAT, 8'd255, 1'b1);
        write_reg(CFG_THRESHOLD, 8'd255);
        queue_frame(SCENE_FLAT, 8'd255, 1'b0);
        write_reg(CFG_THRESHOLD, 8'd0);
        write_reg(CFG_ROWS_SCANNED, 8'd0);
        queue_frame(SCENE_FLAT, 8'd255, 1'b1);
        write_reg(CFG_ROWS_SCANNED, 8'hFF);
        write_reg(CFG_THRESHOLD, 8'd254);
        queue_frame(SCENE_FLAT, 8'd255, 1'b1);
        queue_frame(SCENE_FLAT, 8'd254, 1'b0);
        write_reg(CFG_THRESHOLD, 8'd14);
        write_reg(CFG_ROWS_SCANNED, 8'd29);
        write_reg(CFG_LOST_LIMIT, 8'd255);
        queue_frame(SCENE_SPOTS, 8'd0, 1'b1);
        repeat (3) queue_frame(SCENE_DARK, 8'd0, 1'b1);
        write_reg(CFG_LOST_LIMIT, 8'd2);
        queue_frame(SCENE_DARK, 8'd0, 1'b1);
        write_reg(CFG_LOST_LIMIT, 8'd5);
        queue_partial(700, 1'b1);
        queue_frame(SCENE_SPOTS, 8'd0, 1'b1);
        queue_frame(SCENE_SPOTS, 8'd0, 1'b0);

        run_phase(12, 0, 0);
        run_phase(3, 88, 0);
        run_phase(10, 0, 88);
        run_phase(8, 34, 34);
        drain();

        $display("Checked %0d frame results from %0d pixel items and %0d register writes.",
                 frames_checked, pixels_taken, reg_writes_done);
        $display("Scenes: flat, dark, noise and spot frames, dropped partial frames, wrap.");
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
